/* design/fscl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fscl_pkg: shared types and codes of the serial configuration loader
// Command, status and register codes, the job descriptor passed from the
// front end to the back end, and the pin segment that forms one result beat.
// ----------------------------------------------------------------------------
package fscl_pkg;

   // request commands
   localparam logic [1:0] CMD_START  = 2'd0;
   localparam logic [1:0] CMD_DATA   = 2'd1;
   localparam logic [1:0] CMD_FINISH = 2'd2;

   // segment status codes
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_CONFIGURED = 2'd1;
   localparam logic [1:0] ST_FAILED     = 2'd2;
   localparam logic [1:0] ST_ORDER      = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_RESET_HOLD   = 2'd0;
   localparam logic [1:0] CSR_RELEASE_HOLD = 2'd1;
   localparam logic [1:0] CSR_LEAD_CLOCKS  = 2'd2;
   localparam logic [1:0] CSR_TRAIL_CLOCKS = 2'd3;

   // configuration values after reset
   localparam logic [15:0] RESET_HOLD_DEFAULT   = 16'd100;
   localparam logic [15:0] RELEASE_HOLD_DEFAULT = 16'd2000;
   localparam logic [5:0]  LEAD_CLOCKS_DEFAULT  = 6'd8;
   localparam logic [5:0]  TRAIL_CLOCKS_DEFAULT = 6'd49;

   // sequencer steps
   localparam logic [2:0] STEP_FIRST       = 3'd0;
   localparam logic [2:0] STEP_RELEASE     = 3'd1;
   localparam logic [2:0] STEP_LEAD        = 3'd2;
   localparam logic [2:0] STEP_LAST_BIT    = 3'd7;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   typedef enum logic [1:0] {
      JOB_START,
      JOB_DATA,
      JOB_FINISH,
      JOB_ORDER
   } job_kind_type;

   typedef enum logic {
      PHASE_IDLE,
      PHASE_PROG
   } phase_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   data_byte;
      logic         mosi_held;
      logic         done_pin;
   } job_type;

   typedef struct packed {
      logic [15:0] reset_hold;
      logic [15:0] release_hold;
      logic [5:0]  lead_clocks;
      logic [5:0]  trail_clocks;
   } cfg_type;

   typedef struct packed {
      logic        reset_level;
      logic        select_level;
      logic        mosi_level;
      logic [5:0]  pulse_count;
      logic [15:0] hold_cycles;
      logic        last;
      logic [1:0]  status;
   } segment_type;

endpackage
`default_nettype wire

/* design/fscl_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fscl_front: request intake and classification
// Tracks the programming phase and the held data level, turns each accepted
// request beat into a job for the back end.
// ----------------------------------------------------------------------------
module fscl_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire logic [1:0]      req_command,
   input  wire logic [7:0]      req_data_byte,
   input  wire logic            req_done_pin,
   input  wire logic            queue_full,
   output logic                 push_valid,
   output fscl_pkg::job_type    push_job
);
   import fscl_pkg::*;

   phase_type phase_ff, phase_in;
   logic      mosi_held_ff, mosi_held_in;
   logic      accept;

   assign req_stall  = queue_full;
   assign accept     = req_valid && !queue_full;
   assign push_valid = accept;

   // next phase and held data level
   always_comb begin
      phase_in     = phase_ff;
      mosi_held_in = mosi_held_ff;
      if (accept) begin
         case (req_command)
            CMD_START: begin
               phase_in     = PHASE_PROG;
               mosi_held_in = 1'b0;
            end
            CMD_DATA: begin
               if (phase_ff == PHASE_PROG) begin
                  mosi_held_in = req_data_byte[0];
               end
            end
            CMD_FINISH: begin
               phase_in = PHASE_IDLE;
            end
            default: begin
            end
         endcase
      end
   end

   // classify the request
   always_comb begin
      push_job.data_byte = req_data_byte;
      push_job.mosi_held = mosi_held_ff;
      push_job.done_pin  = req_done_pin;
      if (req_command == CMD_START) begin
         push_job.kind = JOB_START;
      end else if (phase_ff == PHASE_IDLE) begin
         push_job.kind = JOB_ORDER;
      end else begin
         case (req_command)
            CMD_DATA:   push_job.kind = JOB_DATA;
            CMD_FINISH: push_job.kind = JOB_FINISH;
            default:    push_job.kind = JOB_ORDER;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_IDLE;
         mosi_held_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         mosi_held_ff <= mosi_held_in;
      end
   end

endmodule
`default_nettype wire

/* design/fscl_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fscl_queue: job queue between front and back end
// Small register FIFO; lets intake and segment generation stall apart.
// ----------------------------------------------------------------------------
module fscl_queue #(
   parameter int DEPTH = fscl_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push_valid,
   input  wire fscl_pkg::job_type push_job,
   output logic                 full,
   input  wire logic            pop_ready,
   output logic                 pop_valid,
   output fscl_pkg::job_type    pop_job
);
   import fscl_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == FULL_CNT);
   assign pop_valid = (count_ff != '0);
   assign pop_job   = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_ready && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

/* design/fscl_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fscl_back: segment sequencer
// Expands the job at the queue head into pin segments, one per cycle while
// the result channel is not stalled, into the result register.
// ----------------------------------------------------------------------------
module fscl_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire fscl_pkg::cfg_type cfg,
   input  wire logic              pop_valid,
   input  wire fscl_pkg::job_type pop_job,
   output logic                   pop_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output fscl_pkg::segment_type  rsp_seg
);
   import fscl_pkg::*;

   logic [2:0]  step_ff, step_in;
   logic        rsp_valid_ff, rsp_valid_in;
   segment_type seg_ff, seg;
   logic        out_free, advance;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = pop_valid && out_free;
   assign pop_ready = advance && seg.last;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_seg   = seg_ff;

   // segment for the current job and step
   always_comb begin
      seg.reset_level  = 1'b1;
      seg.select_level = 1'b0;
      seg.mosi_level   = 1'b0;
      seg.pulse_count  = '0;
      seg.hold_cycles  = '0;
      seg.last         = 1'b1;
      seg.status       = ST_OK;
      case (pop_job.kind)
         JOB_START: begin
            if (step_ff == STEP_FIRST) begin
               seg.reset_level = 1'b0;
               seg.hold_cycles = cfg.reset_hold;
               seg.last        = 1'b0;
            end else if (step_ff == STEP_RELEASE) begin
               seg.hold_cycles = cfg.release_hold;
               seg.last        = 1'b0;
            end else begin
               seg.pulse_count = cfg.lead_clocks;
            end
         end
         JOB_DATA: begin
            seg.mosi_level  = pop_job.data_byte[STEP_LAST_BIT - step_ff];
            seg.pulse_count = 6'd1;
            seg.last        = (step_ff == STEP_LAST_BIT);
         end
         JOB_FINISH: begin
            seg.mosi_level  = pop_job.mosi_held;
            seg.pulse_count = cfg.trail_clocks;
            seg.status      = pop_job.done_pin ? ST_CONFIGURED : ST_FAILED;
         end
         default: begin
            seg.select_level = 1'b1;
            seg.status       = ST_ORDER;
         end
      endcase
   end

   always_comb begin
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = advance;
      end
      if (advance) begin
         step_in = seg.last ? STEP_FIRST : step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         seg_ff <= seg;
      end
   end

endmodule
`default_nettype wire

/* design/fpga_serial_config_loader.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpga_serial_config_loader: slave-serial configuration segment generator
// Turns start, data and finish commands into pin segments for the loader.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries commands: start, one bitstream byte, or finish with the
//   sampled done pin. rsp_* carries pin segments: reset, select and data
//   levels, a pulse count and a hold count; rsp_last marks the final segment
//   of a command. csr_* writes the four timing registers; the user must
//   write them only while idle; the block does not enforce it. Start
//   gives 3 segments, a data byte 8 (MSB first), finish 1 with the
//   configured/failed status. Data or finish while idle, or an unused code,
//   gives one out-of-order segment and leaves the state alone. The first
//   segment of a command is registered in the job queue and then in the
//   result register. Throughput: the segment sequencer gives one segment
//   per cycle while the receiver does not stall; a short job queue lets
//   requests be taken while the sequencer is still busy.
//   Reset: idle phase, queue empty, no result valid, registers at defaults.
//   A stalled result beat holds; the sequencer and then the queue fill and
//   req_stall rises until the receiver takes beats again.
// ----------------------------------------------------------------------------
module fpga_serial_config_loader #(
   parameter int QUEUE_DEPTH = fscl_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_command,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_done_pin,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_reset_level,
   output logic             rsp_select_level,
   output logic             rsp_mosi_level,
   output logic [5:0]       rsp_pulse_count,
   output logic [15:0]      rsp_hold_cycles,
   output logic             rsp_last,
   output logic [1:0]       rsp_status,
   // register write port
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   import fscl_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   job_type     push_job, pop_job;
   logic        push_valid, queue_full, pop_valid, pop_ready;
   segment_type rsp_seg;

   // timing registers: take the low bits of the write data
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_RESET_HOLD:   cfg_in.reset_hold   = csr_data;
            CSR_RELEASE_HOLD: cfg_in.release_hold = csr_data;
            CSR_LEAD_CLOCKS:  cfg_in.lead_clocks  = csr_data[5:0];
            CSR_TRAIL_CLOCKS: cfg_in.trail_clocks = csr_data[5:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_hold   <= RESET_HOLD_DEFAULT;
         cfg_ff.release_hold <= RELEASE_HOLD_DEFAULT;
         cfg_ff.lead_clocks  <= LEAD_CLOCKS_DEFAULT;
         cfg_ff.trail_clocks <= TRAIL_CLOCKS_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // classify requests and track the programming phase
   fscl_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_data_byte (req_data_byte),
      .req_done_pin  (req_done_pin),
      .queue_full    (queue_full),
      .push_valid    (push_valid),
      .push_job      (push_job)
   );

   // decouple intake from segment generation
   fscl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop_ready  (pop_ready),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job)
   );

   // expand jobs into segments
   fscl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_job   (pop_job),
      .pop_ready (pop_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_seg   (rsp_seg)
   );

   assign rsp_reset_level  = rsp_seg.reset_level;
   assign rsp_select_level = rsp_seg.select_level;
   assign rsp_mosi_level   = rsp_seg.mosi_level;
   assign rsp_pulse_count  = rsp_seg.pulse_count;
   assign rsp_hold_cycles  = rsp_seg.hold_cycles;
   assign rsp_last         = rsp_seg.last;
   assign rsp_status       = rsp_seg.status;

endmodule
`default_nettype wire

/* design/fscl_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fscl_checker: port-level checks of the configuration loader
// Watches the result channel for segment ordering and encoding rules.
// ----------------------------------------------------------------------------
module fscl_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        rsp_reset_level,
   input  wire logic        rsp_select_level,
   input  wire logic        rsp_mosi_level,
   input  wire logic [5:0]  rsp_pulse_count,
   input  wire logic [15:0] rsp_hold_cycles,
   input  wire logic        rsp_last,
   input  wire logic [1:0]  rsp_status
);
   import fscl_pkg::*;

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hold_cycles)
         && $stable(rsp_pulse_count) && $stable(rsp_status) && $stable(rsp_last)
         && $stable(rsp_reset_level) && $stable(rsp_select_level)
         && $stable(rsp_mosi_level))
      else $error("stalled result beat changed");

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // out-of-order beats are single, deselected and idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_ORDER |-> rsp_last && rsp_select_level
         && rsp_pulse_count == 6'd0 && rsp_hold_cycles == 16'd0)
      else $error("malformed out-of-order segment");

   // reset-asserted segment is the first of a start: release follows next
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_reset_level |=>
         !rsp_valid || (rsp_reset_level && !rsp_select_level
            && rsp_pulse_count == 6'd0 && !rsp_last && rsp_status == ST_OK))
      else $error("reset release segment missing");

endmodule

bind fpga_serial_config_loader fscl_checker u_checker (.*);
`default_nettype wire

/* dv/fscl_segment_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fscl_segment_checker: pin segment predictor and scoreboard
// Mirrors the timing registers and the loader phase and expands each request
// beat into the pin segments it must produce. Result beats are compared field
// by field in order against the oldest predicted segment.
// ----------------------------------------------------------------------------
module fscl_segment_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [1:0]  req_command,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_done_pin,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        rsp_reset_level,
   input  wire logic        rsp_select_level,
   input  wire logic        rsp_mosi_level,
   input  wire logic [5:0]  rsp_pulse_count,
   input  wire logic [15:0] rsp_hold_cycles,
   input  wire logic        rsp_last,
   input  wire logic [1:0]  rsp_status,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data,
   output int               mismatches,
   output int               outstanding
);
   import fscl_pkg::*;

   segment_type predicted_segments[$];
   segment_type seen;
   cfg_type     timing;
   phase_type   prog_phase;
   logic        held_mosi;
   int          error_total = 0;

   assign mismatches = error_total;

   task automatic report_mismatch(input string what);
      error_total++;
      $display("[%0t] segment mismatch: %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, want));
   endtask

   task automatic push_segment(input logic rst_level, input logic sel_level,
                               input logic mosi, input logic [5:0] pulses,
                               input logic [15:0] hold, input logic last,
                               input logic [1:0] status);
      segment_type s;
      s.reset_level  = rst_level;
      s.select_level = sel_level;
      s.mosi_level   = mosi;
      s.pulse_count  = pulses;
      s.hold_cycles  = hold;
      s.last         = last;
      s.status       = status;
      predicted_segments.push_back(s);
   endtask

   // expand one command into its segments and advance the loader phase
   task automatic expand_command(input logic [1:0] cmd, input logic [7:0] data,
                                 input logic done);
      int i;
      case (cmd)
         CMD_START: begin
            push_segment(1'b0, 1'b0, 1'b0, 6'd0, timing.reset_hold, 1'b0, ST_OK);
            push_segment(1'b1, 1'b0, 1'b0, 6'd0, timing.release_hold, 1'b0, ST_OK);
            push_segment(1'b1, 1'b0, 1'b0, timing.lead_clocks, 16'd0, 1'b1, ST_OK);
            prog_phase = PHASE_PROG;
            held_mosi  = 1'b0;
         end
         CMD_DATA, CMD_FINISH: begin
            if (prog_phase == PHASE_IDLE) begin
               push_segment(1'b1, 1'b1, 1'b0, 6'd0, 16'd0, 1'b1, ST_ORDER);
            end else if (cmd == CMD_DATA) begin
               // shift out MSB first, one pulse per bit
               for (i = 7; i >= 0; i--)
                  push_segment(1'b1, 1'b0, data[i], 6'd1, 16'd0, i == 0, ST_OK);
               held_mosi = data[0];
            end else begin
               push_segment(1'b1, 1'b0, held_mosi, timing.trail_clocks, 16'd0, 1'b1,
                            done ? ST_CONFIGURED : ST_FAILED);
               prog_phase = PHASE_IDLE;
            end
         end
         default: begin
            push_segment(1'b1, 1'b1, 1'b0, 6'd0, 16'd0, 1'b1, ST_ORDER);
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         predicted_segments.delete();
         timing.reset_hold   = RESET_HOLD_DEFAULT;
         timing.release_hold = RELEASE_HOLD_DEFAULT;
         timing.lead_clocks  = LEAD_CLOCKS_DEFAULT;
         timing.trail_clocks = TRAIL_CLOCKS_DEFAULT;
         prog_phase          = PHASE_IDLE;
         held_mosi           = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_segments.size() == 0) begin
               report_mismatch("result beat with no segment predicted");
            end else begin
               seen = predicted_segments.pop_front();
               check_field("reset_level", 16'(rsp_reset_level), 16'(seen.reset_level));
               check_field("select_level", 16'(rsp_select_level),
                           16'(seen.select_level));
               check_field("mosi_level", 16'(rsp_mosi_level), 16'(seen.mosi_level));
               check_field("pulse_count", 16'(rsp_pulse_count), 16'(seen.pulse_count));
               check_field("hold_cycles", rsp_hold_cycles, seen.hold_cycles);
               check_field("last", 16'(rsp_last), 16'(seen.last));
               check_field("status", 16'(rsp_status), 16'(seen.status));
            end
         end
         if (csr_write) begin
            case (csr_index)
               CSR_RESET_HOLD:   timing.reset_hold   = csr_data;
               CSR_RELEASE_HOLD: timing.release_hold = csr_data;
               CSR_LEAD_CLOCKS:  timing.lead_clocks  = csr_data[5:0];
               CSR_TRAIL_CLOCKS: timing.trail_clocks = csr_data[5:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expand_command(req_command, req_data_byte, req_done_pin);
      end
      outstanding <= predicted_segments.size();
   end

endmodule

/* dv/fpga_serial_config_loader_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpga_serial_config_loader_tb: stimulus and verdict for the config loader
// Drives start, data and finish commands through the request channel under
// varying timing registers and handshake gaps, with a long result hold-off to
// back the loader up. The segment checker beside the block does the segment checking.
// ----------------------------------------------------------------------------
module fpga_serial_config_loader_tb;
   import fscl_pkg::*;

   // command code the loader must treat as out of order
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int SETTLE_CYCLES   = 20;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SESSION_ITEMS   = 76;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = CMD_START;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_done_pin = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_reset_level;
   logic        rsp_select_level;
   logic        rsp_mosi_level;
   logic [5:0]  rsp_pulse_count;
   logic [15:0] rsp_hold_cycles;
   logic        rsp_last;
   logic [1:0]  rsp_status;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = CSR_RESET_HOLD;
   logic [15:0] csr_data = 16'd0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int cycle_count = 0;
   int hold_left = 0;
   bit hold_off_armed = 1'b0;
   bit hold_off_done = 1'b0;
   int mismatches;
   int outstanding;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   fpga_serial_config_loader dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_data_byte    (req_data_byte),
      .req_done_pin     (req_done_pin),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_reset_level  (rsp_reset_level),
      .rsp_select_level (rsp_select_level),
      .rsp_mosi_level   (rsp_mosi_level),
      .rsp_pulse_count  (rsp_pulse_count),
      .rsp_hold_cycles  (rsp_hold_cycles),
      .rsp_last         (rsp_last),
      .rsp_status       (rsp_status),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   fscl_segment_checker segment_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_data_byte    (req_data_byte),
      .req_done_pin     (req_done_pin),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_reset_level  (rsp_reset_level),
      .rsp_select_level (rsp_select_level),
      .rsp_mosi_level   (rsp_mosi_level),
      .rsp_pulse_count  (rsp_pulse_count),
      .rsp_hold_cycles  (rsp_hold_cycles),
      .rsp_last         (rsp_last),
      .rsp_status       (rsp_status),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   // Result side: stall at random, except during the one long hold-off, which
   // is counted here so the sender keeps offering beats while the block fills.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_off_armed && !hold_off_done) begin
         rsp_stall     <= 1'b1;
         hold_left     <= HOLD_OFF_CYCLES;
         hold_off_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Watchdog: end the run if the loader hangs or drops segments.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Offer one request beat and hold it until taken. Gaps lower valid in
   // earlier steps only, so back-to-back beats keep valid high throughout.
   task automatic send_beat(input logic [1:0] cmd, input logic [7:0] data,
                            input logic done);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_data_byte <= data;
      req_done_pin  <= done;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid, wait for every predicted segment, then let the block settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all four timing registers on consecutive edges; only call when idle.
   task automatic write_timing(input logic [15:0] rst_hold, input logic [15:0] rel_hold,
                               input logic [15:0] lead, input logic [15:0] trail);
      logic [15:0] values[4];
      int i;
      values = '{rst_hold, rel_hold, lead, trail};
      for (i = 0; i < 4; i++) begin
         csr_write <= 1'b1;
         csr_index <= i[1:0];
         csr_data  <= values[i];
         @(posedge clock);
      end
      csr_write <= 1'b0;
   endtask

   // Mostly well-formed load sequences (start, 1 to 12 bytes, finish) with random
   // content; mix in stray commands and loads that never finish.
   task automatic load_sessions(input int items);
      int sent;
      int nbytes;
      int k;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(0, 9) == 0) begin
            send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
            sent++;
         end else begin
            nbytes = $urandom_range(1, 12);
            send_beat(CMD_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            for (k = 0; k < nbytes; k++)
               send_beat(CMD_DATA, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            sent += nbytes + 1;
            if ($urandom_range(0, 7) != 0) begin
               send_beat(CMD_FINISH, 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 28;
      recv_idle_pct = 69;

      // Directed part at default timing. Data, finish and the unused code
      // while idle must each give one out-of-order segment.
      send_beat(CMD_DATA, 8'h5A, 1'b0);
      send_beat(CMD_FINISH, 8'h00, 1'b1);
      send_beat(CMD_UNUSED, 8'hFF, 1'b1);
      // full load with edge bytes; the unused code mid-load leaves state alone
      send_beat(CMD_START, 8'h00, 1'b0);
      send_beat(CMD_DATA, 8'h00, 1'b0);
      send_beat(CMD_DATA, 8'hFF, 1'b0);
      send_beat(CMD_DATA, 8'h80, 1'b0);
      send_beat(CMD_DATA, 8'h01, 1'b0);
      send_beat(CMD_UNUSED, 8'h00, 1'b0);
      send_beat(CMD_FINISH, 8'h00, 1'b1);
      // restart while programming, then a failed load ending on a low bit
      send_beat(CMD_START, 8'hFF, 1'b1);
      send_beat(CMD_START, 8'h00, 1'b0);
      send_beat(CMD_DATA, 8'hA5, 1'b1);
      send_beat(CMD_DATA, 8'h5A, 1'b1);
      send_beat(CMD_FINISH, 8'hFF, 1'b0);
      send_beat(CMD_FINISH, 8'hFF, 1'b1);
      wait_idle();

      // largest timing values; all-ones data also exercises the ignored bits
      write_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_beat(CMD_START, 8'h00, 1'b0);
      send_beat(CMD_DATA, 8'h3C, 1'b0);
      send_beat(CMD_FINISH, 8'h00, 1'b1);
      wait_idle();

      // zero counts still give their segments; finish right after start
      write_timing(16'd0, 16'd0, 16'd0, 16'd0);
      send_beat(CMD_START, 8'h00, 1'b0);
      send_beat(CMD_FINISH, 8'h00, 1'b0);
      send_beat(CMD_DATA, 8'hC3, 1'b1);
      wait_idle();

      // random part, sender idles less than receiver
      write_timing(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      load_sessions(SESSION_ITEMS);
      wait_idle();

      // swap the gap rates
      send_idle_pct = 69;
      recv_idle_pct = 28;
      write_timing(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 63)), 16'($urandom_range(0, 63)));
      load_sessions(SESSION_ITEMS);
      wait_idle();

      // no gaps, default timing, and one long result hold-off to fill the block
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_timing(RESET_HOLD_DEFAULT, RELEASE_HOLD_DEFAULT,
                   16'(LEAD_CLOCKS_DEFAULT), 16'(TRAIL_CLOCKS_DEFAULT));
      hold_off_armed = 1'b1;
      load_sessions(SESSION_ITEMS);
      wait_idle();

      if (mismatches == 0 && outstanding == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
